// ----- rtl/core/hsb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsb_pkg: shared types and constants for the RGB to HSB converter
// Pixel and result payloads, the per-stage divider lane and pipeline record,
// and the shift-subtract step used by every divider stage.
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int CHAN_W = 8;
  localparam int OUT_W  = 16;

  // Divisors are kept doubled, so the first step of the long division yields
  // the integer bit. The hue divisor 2*6*d reaches 3060, so it needs 12 bits.
  localparam int DEN_W = 12;

  // Three steps in each of six stages give 18 quotient bits; the last bit is
  // an extra fraction bit that is dropped at the output.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = 6;
  localparam int QUOT_W     = DIV_STEPS * DIV_STAGES;

  // Multiplier for an exact floor(y / 255) on 16-bit y: (y * 0x8081) >> 23.
  localparam logic [15:0] BRIGHT_RECIP = 16'h8081;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] brightness;
  } result_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
  } lane_t;

  typedef struct packed {
    logic              valid;
    lane_t             hue;
    lane_t             sat;
    logic [CHAN_W-1:0] vmax;
  } pipe_t;

  // Runs DIV_STEPS restoring-division steps on one lane. The remainder always
  // stays below the divisor, so the doubled value fits in DEN_W+1 bits.
  function automatic lane_t div_steps(input lane_t lane_in);
    lane_t           lane;
    logic [DEN_W:0]  shifted;
    logic            qbit;
    lane = lane_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      shifted = {lane.rem, 1'b0};
      qbit    = (shifted >= {1'b0, lane.den});
      if (qbit) begin
        shifted = shifted - {1'b0, lane.den};
      end
      lane.rem  = shifted[DEN_W-1:0];
      lane.quot = {lane.quot[QUOT_W-2:0], qbit};
    end
    return lane;
  endfunction

endpackage

// ----- rtl/core/hsb_front.sv -----
// ----------------------------------------------------------------------------
// hsb_front: channel analysis stage
// Finds max, min and their spread, forms the hue sector numerator and sets up
// the hue and saturation divider lanes.
// ----------------------------------------------------------------------------
module hsb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hsb_pkg::pixel_t pixel,
  output hsb_pkg::pipe_t  stage
);

  logic [hsb_pkg::CHAN_W-1:0] vmax;
  logic [hsb_pkg::CHAN_W-1:0] vmin;
  logic [hsb_pkg::CHAN_W-1:0] spread;
  logic [10:0]                six_d;
  logic [10:0]                numer;
  hsb_pkg::pipe_t             stage_next;

  always_comb begin
    vmax = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    vmin = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    if (pixel.blue > vmax) begin
      vmax = pixel.blue;
    end
    if (pixel.blue < vmin) begin
      vmin = pixel.blue;
    end
    spread = vmax - vmin;
    six_d  = {1'b0, spread, 2'b00} + {2'b00, spread, 1'b0};

    // Only the red sector can go negative; it wraps by one full turn.
    if (pixel.red == vmax) begin
      if (pixel.green >= pixel.blue) begin
        numer = {3'b000, pixel.green - pixel.blue};
      end else begin
        numer = six_d - {3'b000, pixel.blue - pixel.green};
      end
    end else if (pixel.green == vmax) begin
      numer = {2'b00, spread, 1'b0} + {3'b000, pixel.blue} - {3'b000, pixel.red};
    end else begin
      numer = {1'b0, spread, 2'b00} + {3'b000, pixel.red} - {3'b000, pixel.green};
    end

    stage_next.valid = in_valid;
    stage_next.vmax  = vmax;

    // A grey or black pixel gets a zero numerator over a nonzero divisor,
    // which makes its quotient zero.
    stage_next.hue.rem  = {1'b0, numer};
    stage_next.hue.den  = (spread == '0) ? hsb_pkg::DEN_W'(2) : {six_d, 1'b0};
    stage_next.hue.quot = '0;

    stage_next.sat.rem  = {4'b0000, spread};
    stage_next.sat.den  = (vmax == '0) ? hsb_pkg::DEN_W'(2) : {3'b000, vmax, 1'b0};
    stage_next.sat.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.hue  <= stage_next.hue;
    stage.sat  <= stage_next.sat;
    stage.vmax <= stage_next.vmax;
  end

endmodule

// ----- rtl/core/hsb_div_stage.sv -----
// ----------------------------------------------------------------------------
// hsb_div_stage: one stage of the pipelined dividers
// Advances the hue and saturation lanes by DIV_STEPS quotient bits each.
// ----------------------------------------------------------------------------
module hsb_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  hsb_pkg::pipe_t stage_in,
  output hsb_pkg::pipe_t stage_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.hue  <= hsb_pkg::div_steps(stage_in.hue);
    stage_out.sat  <= hsb_pkg::div_steps(stage_in.sat);
    stage_out.vmax <= stage_in.vmax;
  end

endmodule

// ----- rtl/core/hsb_back.sv -----
// ----------------------------------------------------------------------------
// hsb_back: output stage
// Trims the quotients to their output formats, computes brightness and
// registers the result with its strobe.
// ----------------------------------------------------------------------------
module hsb_back (
  input  logic             clk,
  input  logic             rst,
  input  hsb_pkg::pipe_t   stage,
  output logic             done,
  output hsb_pkg::result_t result
);

  logic [23:0]        bright_prod;
  hsb_pkg::result_t   result_next;

  always_comb begin
    // max*32768/255 = max*128 + floor(max*128/255).
    bright_prod = {16'h0000, stage.vmax} * {8'h00, hsb_pkg::BRIGHT_RECIP};

    result_next.hue        = stage.hue.quot[16:1];
    result_next.saturation = stage.sat.quot[17:2];
    result_next.brightness = {1'b0, stage.vmax, 7'b0000000} + {8'h00, bright_prod[23:16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ----- rtl/core/rgb_to_hsb_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsb_converter: RGB pixel to hue, saturation and brightness
// The done strobe and the result are registered together in the output
// stage. One pixel is taken every clock cycle and busy never rises. The
// receiver cannot stall, so results leave on the strobe alone. A synchronous
// reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
//
// The pipeline has eight register stages:
//   1. Front stage: finds the largest and smallest channel and their spread,
//      chooses the hue sector from the channel that holds the maximum (red
//      wins ties over green, green over blue) and builds the sector
//      numerator, wrapped into one full turn. It also loads both divider
//      lanes. Divisors are stored doubled, so the first division step
//      produces the integer bit of the quotient.
//   2-7. Six divider stages, each doing three restoring shift-subtract steps
//      on the hue lane (numerator over 6*spread) and on the saturation lane
//      (spread over max) side by side. Eighteen quotient bits come out; the
//      hue keeps sixteen fraction bits and saturation keeps its integer bit
//      and fifteen fraction bits, which gives truncation toward zero.
//   8. Output stage: trims the quotients and computes brightness as
//      max*32768/255 with a reciprocal multiply, then registers the result.
//
// Grey and black pixels enter the dividers with a zero numerator over a
// nonzero divisor, so their hue and saturation come out zero
// without any side flags. No result follows reset until a new request.
module rgb_to_hsb_converter (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hsb_pkg::pixel_t  pixel,
  output logic             done,
  output hsb_pkg::result_t result
);

  hsb_pkg::pipe_t chain [hsb_pkg::DIV_STAGES+1];

  // The pipeline never stalls, so every request is taken.
  assign busy = 1'b0;

  hsb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .pixel    (pixel),
    .stage    (chain[0])
  );

  for (genvar s = 0; s < hsb_pkg::DIV_STAGES; s++) begin : g_div
    hsb_div_stage u_div_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[s]),
      .stage_out (chain[s+1])
    );
  end

  hsb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .stage  (chain[hsb_pkg::DIV_STAGES]),
    .done   (done),
    .result (result)
  );

endmodule
